### rtl/core/assert_macros.svh
// Assertion helpers shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk_i edge, masked while rst_ni is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clk_i edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/core/rmwq_pkg.sv
package rmwq_pkg;

  localparam int THREAD_W  = 8;
  localparam int STATUS_W  = 4;
  localparam int COUNT_W   = 8;
  localparam int WAITERS_W = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  localparam logic KIND_LOCK   = 1'b0;
  localparam logic KIND_UNLOCK = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACQUIRED    = 4'd0,
    ST_NESTED      = 4'd1,
    ST_QUEUED      = 4'd2,
    ST_QUEUE_FULL  = 4'd3,
    ST_STILL_HELD  = 4'd4,
    ST_FREED       = 4'd5,
    ST_HANDED_OVER = 4'd6,
    ST_NOT_LOCKED  = 4'd7,
    ST_NOT_OWNER   = 4'd8,
    ST_OVERFLOW    = 4'd9
  } status_e;

  // Queue commands from the lock logic.
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  // Queue occupancy flags back to the lock logic.
  typedef struct packed {
    logic full;
    logic nonempty;
  } q_flags_t;

endpackage

### rtl/core/rmwq_queue.sv
module rmwq_queue #(
  parameter int QUEUE_DEPTH = 8,
  parameter int ID_W        = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rmwq_pkg::q_ctl_t                 ctl_i,
  input  logic [ID_W-1:0]                  push_id_i,
  output logic [ID_W-1:0]                  head_id_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] used_o,
  output rmwq_pkg::q_flags_t               flags_o
);

  localparam int PtrW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int UsedW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0]  PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [UsedW-1:0] UsedMax = UsedW'(QUEUE_DEPTH);

  logic [ID_W-1:0]  mem [QUEUE_DEPTH];
  logic [PtrW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [UsedW-1:0] used_q, used_d;
  logic [ID_W-1:0]  head_data_q;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    used_d = used_q;
    if (ctl_i.push) begin
      tail_d = (tail_q == PtrLast) ? '0 : tail_q + 1'b1;
      used_d = used_q + 1'b1;
    end
    if (ctl_i.pop) begin
      head_d = (head_q == PtrLast) ? '0 : head_q + 1'b1;
      used_d = used_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      used_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      used_q <= used_d;
    end
  end

  // Registered read of the next head; bypass when the push lands there.
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[tail_q] <= push_id_i;
    end
    if (ctl_i.push && (tail_q == head_d)) begin
      head_data_q <= push_id_i;
    end else begin
      head_data_q <= mem[head_d];
    end
  end

  assign head_id_o        = head_data_q;
  assign used_o           = used_q;
  assign flags_o.full     = (used_q == UsedMax);
  assign flags_o.nonempty = (used_q != '0);

  `include "assert_macros.svh"

  `ASSERT_CLK(a_no_push_full, ctl_i.push |-> !flags_o.full, "push into full queue")
  `ASSERT_CLK(a_no_pop_empty, ctl_i.pop |-> flags_o.nonempty, "pop from empty queue")
  `ASSERT_CLK(a_used_bound, used_q <= UsedMax, "queue count beyond depth")

endmodule

### rtl/core/recursive_mutex_with_wait_queue_core.sv
// Channel   Handshake                    Fields
// request   start && !busy               kind_i, thread_id_i
// result    result_valid_o, one cycle    status_o, owner_valid_o, owner_id_o,
//                                        nest_count_o, waiters_o
//
// One request per cycle, back to back; busy never rises.
// A request goes through the request register, then one pass of owner
// compare, count update and queue pointer update into the result register.
// That state update loop sets the rate of one request per clock.
// Reset clears owner, count, queue pointers and valids; queue entries are
// not cleared and take no pass. The receiver cannot stall: each result
// shows for exactly one cycle.
module recursive_mutex_with_wait_queue_core #(
  parameter int QUEUE_DEPTH = 8,
  parameter int ID_BITS     = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           kind_i,
  input  logic [rmwq_pkg::THREAD_W-1:0]  thread_id_i,
  output logic                           result_valid_o,
  output logic [rmwq_pkg::STATUS_W-1:0]  status_o,
  output logic                           owner_valid_o,
  output logic [rmwq_pkg::THREAD_W-1:0]  owner_id_o,
  output logic [rmwq_pkg::COUNT_W-1:0]   nest_count_o,
  output logic [rmwq_pkg::WAITERS_W-1:0] waiters_o
);

  // Only the low ID_BITS of an id count; the port caps it at 8 bits.
  localparam int IdW   = (ID_BITS < rmwq_pkg::THREAD_W) ? ID_BITS : rmwq_pkg::THREAD_W;
  localparam int UsedW = $clog2(QUEUE_DEPTH + 1);

  // request register
  logic           in_valid_q;
  logic           kind_q;
  logic [IdW-1:0] id_q;

  // mutex state
  logic                         holder_valid_q, holder_valid_d;
  logic [IdW-1:0]               holder_q, holder_d;
  logic [rmwq_pkg::COUNT_W-1:0] count_q, count_d;

  // queue
  rmwq_pkg::q_ctl_t   q_ctl;
  rmwq_pkg::q_flags_t q_flags;
  logic [IdW-1:0]     q_head_id;
  logic [UsedW-1:0]   q_used, used_after;

  rmwq_pkg::status_e status;

  // result register
  logic                         res_valid_q;
  rmwq_pkg::status_e            res_status_q;
  logic                         res_owner_valid_q;
  logic [IdW-1:0]               res_owner_q;
  logic [rmwq_pkg::COUNT_W-1:0] res_count_q;
  logic [UsedW-1:0]             res_used_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      kind_q <= kind_i;
      id_q   <= IdW'(thread_id_i);
    end
  end

  rmwq_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_W       (IdW)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (q_ctl),
    .push_id_i(id_q),
    .head_id_o(q_head_id),
    .used_o   (q_used),
    .flags_o  (q_flags)
  );

  // Lock / unlock decision; priority order follows the checks below.
  always_comb begin
    holder_valid_d = holder_valid_q;
    holder_d       = holder_q;
    count_d        = count_q;
    q_ctl          = '0;
    status         = rmwq_pkg::ST_ACQUIRED;
    if (kind_q == rmwq_pkg::KIND_LOCK) begin
      priority if (!holder_valid_q) begin
        holder_valid_d = 1'b1;
        holder_d       = id_q;
        count_d        = 8'd1;
        status         = rmwq_pkg::ST_ACQUIRED;
      end else if (holder_q == id_q) begin
        if (count_q >= rmwq_pkg::COUNT_MAX) begin
          status = rmwq_pkg::ST_OVERFLOW;
        end else begin
          count_d = count_q + 1'b1;
          status  = rmwq_pkg::ST_NESTED;
        end
      end else if (q_flags.full) begin
        status = rmwq_pkg::ST_QUEUE_FULL;
      end else begin
        q_ctl.push = 1'b1;
        status     = rmwq_pkg::ST_QUEUED;
      end
    end else begin
      priority if (!holder_valid_q) begin
        status = rmwq_pkg::ST_NOT_LOCKED;
      end else if (holder_q != id_q) begin
        status = rmwq_pkg::ST_NOT_OWNER;
      end else if (count_q > 8'd1) begin
        count_d = count_q - 1'b1;
        status  = rmwq_pkg::ST_STILL_HELD;
      end else if (q_flags.nonempty) begin
        // direct hand-over to the oldest waiter
        q_ctl.pop = 1'b1;
        holder_d  = q_head_id;
        count_d   = 8'd1;
        status    = rmwq_pkg::ST_HANDED_OVER;
      end else begin
        holder_valid_d = 1'b0;
        holder_d       = '0;
        count_d        = '0;
        status         = rmwq_pkg::ST_FREED;
      end
    end
    // idle cycles leave everything alone
    if (!in_valid_q) begin
      holder_valid_d = holder_valid_q;
      holder_d       = holder_q;
      count_d        = count_q;
      q_ctl          = '0;
    end
  end

  assign used_after = q_used + UsedW'(q_ctl.push) - UsedW'(q_ctl.pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holder_valid_q <= 1'b0;
      holder_q       <= '0;
      count_q        <= '0;
      res_valid_q    <= 1'b0;
    end else begin
      holder_valid_q <= holder_valid_d;
      holder_q       <= holder_d;
      count_q        <= count_d;
      res_valid_q    <= in_valid_q;
    end
  end

  // A free mutex always has holder and count at zero, so no masking needed.
  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      res_status_q      <= status;
      res_owner_valid_q <= holder_valid_d;
      res_owner_q       <= holder_d;
      res_count_q       <= count_d;
      res_used_q        <= used_after;
    end
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign owner_valid_o  = res_owner_valid_q;
  assign owner_id_o     = rmwq_pkg::THREAD_W'(res_owner_q);
  assign nest_count_o   = res_count_q;
  assign waiters_o      = rmwq_pkg::WAITERS_W'(res_used_q);

  `include "assert_macros.svh"

  `ASSERT_CLK(a_res_follows_req, result_valid_o |-> $past(in_valid_q),
      "result beat without request")
  `ASSERT_CLK(a_held_count_nonzero, holder_valid_q |-> (count_q != '0),
      "held mutex with zero count")
  `ASSERT_CLK(a_free_is_clean, !holder_valid_q |-> (holder_q == '0 && count_q == '0),
      "free mutex keeps owner or count")
  `ASSERT_ALWAYS(a_busy_low, !busy, "busy raised")

endmodule
